/* rtl/abpc_pkg.sv */
// Package for the audio capture block pool: item types, function and register codes,
// free-list request type and default sizes. No dependencies.
package abpc_pkg;

    localparam int NUM_BLOCKS_DEF       = 64;
    localparam int MAX_BLOCK_FRAMES_DEF = 4096;
    localparam int MIN_BLOCK_FRAMES     = 256;

    localparam int FUNC_W        = 2;
    localparam int SAMPLE_W      = 16;
    localparam int BLOCK_ID_W    = 6;
    localparam int ADDR_W        = 18;
    localparam int FRAME_CNT_W   = 13;
    localparam int PEAK_W        = 15;
    localparam int DROP_W        = 32;
    localparam int CAPTURE_W     = 40;
    localparam int FPB_W         = 13;
    localparam int CHAN_W        = 2;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 13;

    localparam logic [FUNC_W-1:0] FUNC_FRAME  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RETURN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEAK   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_PER_BLOCK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT    = 1'd1;

    localparam logic [FPB_W-1:0]  FPB_RESET  = 13'd4096;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]          func;
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
        logic [BLOCK_ID_W-1:0]      block_id;
    } in_item_t;

    typedef struct packed {
        logic                   write_valid;
        logic [ADDR_W-1:0]      write_address;
        logic                   block_done;
        logic [BLOCK_ID_W-1:0]  done_block_id;
        logic [FRAME_CNT_W-1:0] done_frame_count;
        logic [PEAK_W-1:0]      peak_reading;
        logic [DROP_W-1:0]      dropped_total;
        logic [CAPTURE_W-1:0]   captured_total;
        logic                   return_refused;
    } out_item_t;

    typedef struct packed {
        logic                  pop;
        logic                  push;
        logic [BLOCK_ID_W-1:0] push_id;
    } fl_req_t;

endpackage

/* rtl/abpc_free_list.sv */
// Free list of block ids: a ring memory with per-entry written bits and a registered head read.
// Depends on abpc_pkg.
module abpc_free_list #(
    parameter int NUM_BLOCKS = abpc_pkg::NUM_BLOCKS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  abpc_pkg::fl_req_t                     req,
    output logic [((($clog2(NUM_BLOCKS)) > abpc_pkg::BLOCK_ID_W) ?
                   $clog2(NUM_BLOCKS) : abpc_pkg::BLOCK_ID_W)-1:0] head_id,
    output logic [$clog2(NUM_BLOCKS+1)-1:0]       count
);

    localparam int ID_W    = $clog2(NUM_BLOCKS);
    localparam int ENTRY_W = (ID_W > abpc_pkg::BLOCK_ID_W) ? ID_W : abpc_pkg::BLOCK_ID_W;
    localparam int COUNT_W = $clog2(NUM_BLOCKS+1);
    localparam logic [ID_W-1:0]    LAST_SLOT  = ID_W'(NUM_BLOCKS-1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(NUM_BLOCKS);

    logic [ENTRY_W-1:0]     mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0]  written_reg;
    logic [ID_W-1:0]        head_reg;
    logic [ID_W-1:0]        head_next;
    logic [ID_W-1:0]        tail_reg;
    logic [ID_W-1:0]        tail_next;
    logic [COUNT_W-1:0]     count_reg;
    logic [ENTRY_W-1:0]     push_entry;
    logic                   bypass;
    logic                   bypass_reg;
    logic [ENTRY_W-1:0]     bypass_data_reg;
    logic                   sel_mem_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;

    function automatic logic [ID_W-1:0] ring_next(input logic [ID_W-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + ID_W'(1);
    endfunction

    assign head_next  = req.pop  ? ring_next(head_reg) : head_reg;
    assign tail_next  = req.push ? ring_next(tail_reg) : tail_reg;
    assign push_entry = ENTRY_W'(req.push_id);
    assign bypass     = req.push && (tail_reg == head_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= FULL_COUNT;
            written_reg <= '0;
            bypass_reg  <= 1'b0;
            sel_mem_reg <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            bypass_reg  <= bypass;
            sel_mem_reg <= written_reg[head_next];
            if (req.push)
            begin
                written_reg[tail_reg] <= 1'b1;
                count_reg             <= count_reg + COUNT_W'(1);
            end
            else if (req.pop)
            begin
                count_reg <= count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[tail_reg] <= push_entry;
        end
        rd_data_reg     <= mem[head_next];
        bypass_data_reg <= push_entry;
    end

    assign head_id = bypass_reg  ? bypass_data_reg :
                     sel_mem_reg ? rd_data_reg     : ENTRY_W'(head_reg);
    assign count   = count_reg;

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        req.pop |-> count_reg != '0)
        else $error("Free list popped while empty.");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        req.push |-> count_reg != FULL_COUNT)
        else $error("Free list pushed while full.");

    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.pop && req.push))
        else $error("Free list popped and pushed in one cycle.");

endmodule

/* rtl/audio_block_pool_capture_top.sv */
// Top level of the audio capture block pool with peak meter.
// Depends on abpc_pkg and abpc_free_list.

// The block accepts one item per clock cycle unless in_stall is raised, and returns exactly one
// result item for each, passing it through the input register and then the result register.
// A stall on the result side holds the result register and then the input register; the free
// list head is read from a registered memory port that is refreshed every cycle, so a block
// can be opened on any frame. Configuration writes take effect on the next processed item.
module audio_block_pool_capture_top #(
    parameter int NUM_BLOCKS       = abpc_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_BLOCK_FRAMES = abpc_pkg::MAX_BLOCK_FRAMES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  abpc_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output abpc_pkg::out_item_t                 out_item,
    input  logic                                cfg_write,
    input  logic [abpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [abpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ID_W    = $clog2(NUM_BLOCKS);
    localparam int ENTRY_W = (ID_W > abpc_pkg::BLOCK_ID_W) ? ID_W : abpc_pkg::BLOCK_ID_W;
    localparam int COUNT_W = $clog2(NUM_BLOCKS+1);
    localparam int FILL_W  = $clog2(MAX_BLOCK_FRAMES+1);
    localparam int CMP_W   = (FILL_W > abpc_pkg::FPB_W) ? FILL_W : abpc_pkg::FPB_W;
    localparam int ADDR_W  = abpc_pkg::ADDR_W;
    localparam logic [CMP_W-1:0]  LIMIT_MIN    = CMP_W'(abpc_pkg::MIN_BLOCK_FRAMES);
    localparam logic [CMP_W-1:0]  LIMIT_MAX    = CMP_W'(MAX_BLOCK_FRAMES);
    localparam logic [ADDR_W-1:0] FRAME_STRIDE = ADDR_W'(MAX_BLOCK_FRAMES);
    localparam logic [COUNT_W-1:0] FULL_COUNT  = COUNT_W'(NUM_BLOCKS);

    logic [abpc_pkg::FPB_W-1:0]     fpb_reg;
    logic [abpc_pkg::CHAN_W-1:0]    chan_reg;

    logic                           item_valid_reg;
    abpc_pkg::in_item_t             item_reg;
    logic                           out_valid_reg;
    abpc_pkg::out_item_t            out_reg;
    abpc_pkg::out_item_t            out_next;
    logic                           advance;
    logic                           accept;

    logic                           open_valid_reg;
    logic                           open_valid_next;
    logic [ENTRY_W-1:0]             open_block_reg;
    logic [ENTRY_W-1:0]             open_block_next;
    logic [FILL_W-1:0]              fill_reg;
    logic [FILL_W-1:0]              fill_next;
    logic [abpc_pkg::PEAK_W-1:0]    peak_reg;
    logic [abpc_pkg::PEAK_W-1:0]    peak_next;
    logic [abpc_pkg::DROP_W-1:0]    drop_reg;
    logic [abpc_pkg::DROP_W-1:0]    drop_next;
    logic [abpc_pkg::CAPTURE_W-1:0] capture_reg;
    logic [abpc_pkg::CAPTURE_W-1:0] capture_next;

    abpc_pkg::fl_req_t              fl_req;
    logic [ENTRY_W-1:0]             fl_head_id;
    logic [COUNT_W-1:0]             fl_count;

    logic [CMP_W-1:0]               limit;
    logic [abpc_pkg::PEAK_W-1:0]    mag_left;
    logic [abpc_pkg::PEAK_W-1:0]    mag_right;
    logic [abpc_pkg::PEAK_W-1:0]    mag_frame;

    function automatic logic [abpc_pkg::PEAK_W-1:0] magnitude(
        input logic signed [abpc_pkg::SAMPLE_W-1:0] s);
        logic [abpc_pkg::SAMPLE_W-1:0] neg;
        neg = abpc_pkg::SAMPLE_W'(-s);
        if (!s[abpc_pkg::SAMPLE_W-1])
        begin
            return abpc_pkg::PEAK_W'(s);
        end
        else if (neg[abpc_pkg::SAMPLE_W-1])
        begin
            return '1;
        end
        else
        begin
            return abpc_pkg::PEAK_W'(neg);
        end
    endfunction

    abpc_free_list #(
        .NUM_BLOCKS(NUM_BLOCKS)
    ) u_free_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (fl_req),
        .head_id(fl_head_id),
        .count  (fl_count)
    );

    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (CMP_W'(fpb_reg) < LIMIT_MIN)
        begin
            limit = LIMIT_MIN;
        end
        else if (CMP_W'(fpb_reg) > LIMIT_MAX)
        begin
            limit = LIMIT_MAX;
        end
        else
        begin
            limit = CMP_W'(fpb_reg);
        end
    end

    assign mag_left  = magnitude(item_reg.left_sample);
    assign mag_right = magnitude(item_reg.right_sample);
    assign mag_frame = (chan_reg[1] && (mag_right > mag_left)) ? mag_right : mag_left;

    always_comb
    begin
        logic [FILL_W-1:0] fill_inc;
        logic [ADDR_W-1:0] addr_base;
        logic              opened;
        logic [ENTRY_W-1:0] blk;

        out_next        = '0;
        fl_req          = '0;
        open_valid_next = open_valid_reg;
        open_block_next = open_block_reg;
        fill_next       = fill_reg;
        peak_next       = peak_reg;
        drop_next       = drop_reg;
        capture_next    = capture_reg;
        fill_inc        = '0;
        addr_base       = '0;
        opened          = 1'b0;
        blk             = open_block_reg;

        if (advance)
        begin
            case (item_reg.func)
                abpc_pkg::FUNC_FRAME:
                begin
                    if (capture_reg != '1)
                    begin
                        capture_next = capture_reg + abpc_pkg::CAPTURE_W'(1);
                    end
                    if (!open_valid_reg && (fl_count != '0))
                    begin
                        opened     = 1'b1;
                        fl_req.pop = 1'b1;
                        blk        = fl_head_id;
                    end
                    if (!open_valid_reg && !opened)
                    begin
                        if (drop_reg != '1)
                        begin
                            drop_next = drop_reg + abpc_pkg::DROP_W'(1);
                        end
                    end
                    else
                    begin
                        if (mag_frame > peak_reg)
                        begin
                            peak_next = mag_frame;
                        end
                        fill_inc = opened ? FILL_W'(1) : fill_reg + FILL_W'(1);
                        addr_base = ADDR_W'(blk) * FRAME_STRIDE;
                        out_next.write_valid   = 1'b1;
                        out_next.write_address = opened ? addr_base
                                                        : addr_base + ADDR_W'(fill_reg);
                        open_block_next = blk;
                        if (CMP_W'(fill_inc) >= limit)
                        begin
                            out_next.block_done       = 1'b1;
                            out_next.done_block_id    = abpc_pkg::BLOCK_ID_W'(blk);
                            out_next.done_frame_count = abpc_pkg::FRAME_CNT_W'(fill_inc);
                            open_valid_next = 1'b0;
                            fill_next       = '0;
                        end
                        else
                        begin
                            open_valid_next = 1'b1;
                            fill_next       = fill_inc;
                        end
                    end
                end
                abpc_pkg::FUNC_RETURN:
                begin
                    if (fl_count == FULL_COUNT)
                    begin
                        out_next.return_refused = 1'b1;
                    end
                    else
                    begin
                        fl_req.push    = 1'b1;
                        fl_req.push_id = item_reg.block_id;
                    end
                end
                abpc_pkg::FUNC_PEAK:
                begin
                    out_next.peak_reading = peak_reg;
                    peak_next             = '0;
                end
                abpc_pkg::FUNC_FLUSH:
                begin
                    if (open_valid_reg && (fill_reg != '0))
                    begin
                        out_next.block_done       = 1'b1;
                        out_next.done_block_id    = abpc_pkg::BLOCK_ID_W'(open_block_reg);
                        out_next.done_frame_count = abpc_pkg::FRAME_CNT_W'(fill_reg);
                        open_valid_next = 1'b0;
                        fill_next       = '0;
                    end
                end
                default:
                begin
                    out_next = '0;
                end
            endcase
            out_next.dropped_total  = drop_next;
            out_next.captured_total = capture_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fpb_reg        <= abpc_pkg::FPB_RESET;
            chan_reg       <= abpc_pkg::CHAN_RESET;
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            open_valid_reg <= 1'b0;
            open_block_reg <= '0;
            fill_reg       <= '0;
            peak_reg       <= '0;
            drop_reg       <= '0;
            capture_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == abpc_pkg::CFG_FRAMES_PER_BLOCK)
                begin
                    fpb_reg <= abpc_pkg::FPB_W'(cfg_data);
                end
                else if (cfg_index == abpc_pkg::CFG_CHANNEL_COUNT)
                begin
                    chan_reg <= abpc_pkg::CHAN_W'(cfg_data);
                end
            end
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            open_valid_reg <= open_valid_next;
            open_block_reg <= open_block_next;
            fill_reg       <= fill_next;
            peak_reg       <= peak_next;
            drop_reg       <= drop_next;
            capture_reg    <= capture_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !open_valid_reg |-> fill_reg == '0)
        else $error("Fill index is nonzero with no open block.");

    a_write_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.write_valid |->
            out_reg.peak_reading == '0 && !out_reg.return_refused)
        else $error("A stored frame carries peak or return fields.");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(fill_reg) && $stable(open_valid_reg) && $stable(peak_reg))
        else $error("Block state changed without a processed item.");

endmodule
